### design/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, constants and echo tables of the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int LINE_CAPACITY_DEF = 32;
    localparam int CMD_QDEPTH        = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
    localparam int LIMIT_W    = 7;
    localparam int LEN_W      = 6;
    localparam int SEQ_W      = 3;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_OUT_LIMIT = '0;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET        = 7'd32;

    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PRINT,
        OP_ERASE,
        OP_INTR,
        OP_LINE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ECHO,
        ST_DREAD,
        ST_DSEND
    } t_state;

    function automatic logic [SEQ_W-1:0] echo_count(input t_op op);
        logic [SEQ_W-1:0] n;
        case (op)
            OP_LINE:  n = 3'd2;
            OP_ERASE: n = 3'd3;
            OP_INTR:  n = 3'd5;
            default:  n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] echo_byte(input t_op op, input logic [SEQ_W-1:0] seq,
                                             input logic [7:0] data);
        logic [7:0] b;
        case (op)
            OP_LINE:  b = (seq == 3'd0) ? CH_SPACE : CH_LF;
            OP_ERASE: b = (seq == 3'd1) ? CH_SPACE : CH_BS;
            OP_INTR: begin
                case (seq)
                    3'd0:    b = CH_CARET;
                    3'd1:    b = CH_C;
                    3'd2:    b = CH_LF;
                    3'd3:    b = CH_GT;
                    default: b = CH_SPACE;
                endcase
            end
            default:  b = data;
        endcase
        return b;
    endfunction

endpackage

### design/serial_line_editor_core.sv
// ----------------------------------------------------------------------------
// serial_line_editor_core
// Terminal line editor with echo: edits a command line from received bytes.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s         in   i_s_tvalid / o_s_tready    tdata[7:0] rx_byte
//  m         out  o_m_tvalid / i_m_tready    tdata byte+length, tuser kind, tlast
//  apb       in   i_psel / i_penable         line_out_limit at byte address 0
//
//  A word is taken into a command queue of QUEUE_DEPTH entries (two by default).
//  The back part pops each command in ST_IDLE, then sends each echo word from
//  ST_ECHO and each line word through ST_DREAD and ST_DSEND (registered line
//  store read); output stalls hold it in ST_ECHO and ST_DSEND.
//  No clearing pass after reset; ignored bytes never reach the queue.
// ----------------------------------------------------------------------------
module serial_line_editor_core #(
    parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF,
    parameter int QUEUE_DEPTH   = sle_pkg::CMD_QDEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,  // [7:0] rx_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [sle_pkg::OUT_DATA_W-1:0]    o_m_tdata,  // [7:0] out_byte, [13:8] line_length
    output logic                              o_m_tuser,  // [0] out_kind
    output logic                              o_m_tlast,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [sle_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  logic [sle_pkg::CFG_DATA_W-1:0]    i_pwdata,
    output logic [sle_pkg::CFG_DATA_W-1:0]    o_prdata,
    output logic                              o_pready
);

    logic [sle_pkg::LIMIT_W-1:0] r_line_out_limit;
    logic                        reg_hit;
    logic                        q_full;
    logic                        push;
    logic                        pop;
    sle_pkg::t_cmd               cmd;
    sle_pkg::t_q_head            head;

    assign o_pready = 1'b1;
    assign reg_hit  = (i_paddr[sle_pkg::CFG_ADDR_W-1:2] == sle_pkg::REG_LINE_OUT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_out_limit <= sle_pkg::LIMIT_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready && reg_hit) begin
            r_line_out_limit <= i_pwdata[sle_pkg::LIMIT_W-1:0];
        end
    end

    assign o_prdata = reg_hit ? sle_pkg::CFG_DATA_W'(r_line_out_limit) : '0;

    sle_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_q_full   (q_full),
        .o_s_tready (o_s_tready),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    sle_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    sle_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_limit    (r_line_out_limit),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef SYNTHESIS
    a_line_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[13:8] != 6'd0)
        else $error("line word with zero length");

    a_echo_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[13:8] == 6'd0)
        else $error("echo word with non-zero length");

    a_line_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[7:0] >= sle_pkg::CH_SPACE && o_m_tdata[7:0] <= sle_pkg::CH_TILDE)
        else $error("line word not printable");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("command queue overflow");
`endif

endmodule

### design/sle_front.sv
// ----------------------------------------------------------------------------
// sle_front
// Input side: takes received words and sorts them into editing commands.
// ----------------------------------------------------------------------------
module sle_front (
    input  logic              i_s_tvalid,
    input  logic [7:0]        i_s_tdata,   // [7:0] rx_byte
    input  logic              i_q_full,
    output logic              o_s_tready,
    output logic              o_push,
    output sle_pkg::t_cmd     o_cmd
);

    sle_pkg::t_op op;

    always_comb begin
        case (i_s_tdata) inside
            sle_pkg::CH_CR, sle_pkg::CH_LF:              op = sle_pkg::OP_LINE;
            sle_pkg::CH_BS, sle_pkg::CH_DEL:             op = sle_pkg::OP_ERASE;
            sle_pkg::CH_ETX:                             op = sle_pkg::OP_INTR;
            [sle_pkg::CH_SPACE:sle_pkg::CH_TILDE]:       op = sle_pkg::OP_PRINT;
            default:                                     op = sle_pkg::OP_NONE;
        endcase
    end

    assign o_s_tready = !i_q_full;
    // ignored bytes are dropped here and never queued
    assign o_push     = i_s_tvalid && !i_q_full && (op != sle_pkg::OP_NONE);
    assign o_cmd.op   = op;
    assign o_cmd.data = i_s_tdata;

endmodule

### design/sle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sle_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sle_cmd_fifo #(
    parameter int DEPTH = sle_pkg::CMD_QDEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sle_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output sle_pkg::t_q_head  o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sle_pkg::t_cmd   r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_count;
    logic            do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rp];

endmodule

### design/sle_back.sv
// ----------------------------------------------------------------------------
// sle_back
// Execution side: line store, fill level, echo sequencer and line dump.
// ----------------------------------------------------------------------------
module sle_back #(
    parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sle_pkg::t_q_head              i_head,
    output logic                          o_pop,
    input  logic [sle_pkg::LIMIT_W-1:0]   i_limit,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [sle_pkg::OUT_DATA_W-1:0] o_m_tdata,  // [7:0] out_byte, [13:8] line_length
    output logic                          o_m_tuser,  // [0] out_kind
    output logic                          o_m_tlast
);

    localparam int FW = $clog2(LINE_CAPACITY);

    sle_pkg::t_state           r_state, n_state;
    logic [7:0]                r_mem [LINE_CAPACITY];
    logic [7:0]                r_rd_data;
    logic [FW-1:0]             r_fill;
    logic [FW-1:0]             r_len;
    logic [FW-1:0]             r_emit;
    logic [FW-1:0]             r_idx;
    logic [sle_pkg::SEQ_W-1:0] r_seq;
    sle_pkg::t_op              r_op;
    logic [7:0]                r_data;

    logic                      r_out_valid;
    logic                      r_out_kind;
    logic [7:0]                r_out_byte;
    logic [FW-1:0]             r_out_len;
    logic                      r_out_last;

    logic                      out_free;
    logic                      has_res;
    logic                      echo_end;
    logic                      dump_end;
    logic                      do_dump;
    logic [sle_pkg::LIMIT_W-1:0] lim_m1;
    logic [FW-1:0]             emit_calc;

    logic                      load;
    logic                      ld_kind;
    logic [7:0]                ld_byte;
    logic                      ld_last;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        case (i_head.cmd.op)
            sle_pkg::OP_PRINT: has_res = (r_fill < FW'(LINE_CAPACITY - 1));
            sle_pkg::OP_ERASE: has_res = (r_fill != '0);
            sle_pkg::OP_LINE:  has_res = (r_fill != '0);
            sle_pkg::OP_INTR:  has_res = 1'b1;
            default:           has_res = 1'b0;
        endcase
    end

    assign lim_m1    = (i_limit == '0) ? '0 : i_limit - 1'b1;
    assign emit_calc = (sle_pkg::LIMIT_W'(r_fill) < lim_m1) ? r_fill : FW'(lim_m1);

    assign echo_end = (r_seq == sle_pkg::echo_count(r_op) - 1'b1);
    assign do_dump  = (r_op == sle_pkg::OP_LINE) && (r_emit != '0);
    assign dump_end = (r_idx == r_emit - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sle_pkg::ST_IDLE: begin
                if (i_head.valid && has_res) begin
                    n_state = sle_pkg::ST_ECHO;
                end
            end
            sle_pkg::ST_ECHO: begin
                if (out_free && echo_end) begin
                    n_state = do_dump ? sle_pkg::ST_DREAD : sle_pkg::ST_IDLE;
                end
            end
            sle_pkg::ST_DREAD: n_state = sle_pkg::ST_DSEND;
            sle_pkg::ST_DSEND: begin
                if (out_free) begin
                    n_state = dump_end ? sle_pkg::ST_IDLE : sle_pkg::ST_DREAD;
                end
            end
            default: n_state = sle_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop   = 1'b0;
        load    = 1'b0;
        ld_kind = sle_pkg::KIND_ECHO;
        ld_byte = sle_pkg::echo_byte(r_op, r_seq, r_data);
        ld_last = 1'b0;
        case (r_state)
            sle_pkg::ST_IDLE: o_pop = i_head.valid;
            sle_pkg::ST_ECHO: begin
                load    = out_free;
                ld_last = echo_end && !do_dump;
            end
            sle_pkg::ST_DSEND: begin
                load    = out_free;
                ld_kind = sle_pkg::KIND_LINE;
                ld_byte = r_rd_data;
                ld_last = dump_end;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sle_pkg::ST_IDLE && i_head.valid && has_res &&
            i_head.cmd.op == sle_pkg::OP_PRINT) begin
            r_mem[r_fill] <= i_head.cmd.data;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sle_pkg::ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && has_res) begin
                case (i_head.cmd.op)
                    sle_pkg::OP_PRINT: r_fill <= r_fill + 1'b1;
                    sle_pkg::OP_ERASE: r_fill <= r_fill - 1'b1;
                    sle_pkg::OP_INTR:  r_fill <= '0;
                    sle_pkg::OP_LINE:  r_fill <= '0;
                    default:           r_fill <= r_fill;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op   <= i_head.cmd.op;
            r_data <= i_head.cmd.data;
            r_seq  <= '0;
            r_idx  <= '0;
            r_len  <= r_fill;
            r_emit <= emit_calc;
        end else begin
            if (r_state == sle_pkg::ST_ECHO && load) begin
                r_seq <= r_seq + 1'b1;
            end
            if (r_state == sle_pkg::ST_DSEND && load) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (load) begin
            r_out_kind <= ld_kind;
            r_out_byte <= ld_byte;
            r_out_len  <= (ld_kind == sle_pkg::KIND_LINE) ? r_len : '0;
            r_out_last <= ld_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, sle_pkg::LEN_W'(r_out_len), r_out_byte};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule
